[rtl/core/heq_pkg.sv]
package heq_pkg;

    localparam int PIX_W        = 8;
    localparam int BINS         = 256;
    localparam int BIN_W        = 8;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_SIDE_DEF = 1024;
    localparam int MAP_MUL      = 510;
    localparam int MAP_MUL_W    = 9;
    localparam int Q_W          = 8;
    localparam int STEP_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT = 2'd1;

    typedef struct packed {
        logic             count_en;
        logic             remap_en;
        logic             acc;
        logic             mul;
        logic             div;
        logic             wr_tbl;
        logic [BIN_W-1:0] bin;
    } heq_cmd_t;

    typedef struct packed {
        logic cfg_wr;
        logic count_last;
        logic remap_last;
    } heq_sts_t;

endpackage

[rtl/core/heq_in_if.sv]
interface heq_in_if import heq_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

[rtl/core/heq_out_if.sv]
interface heq_out_if import heq_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             last_pixel;

    modport source (output valid, output pixel_out, output last_pixel, input ready);
    modport sink (input valid, input pixel_out, input last_pixel, output ready);
endinterface

[rtl/core/histogram_equalizer_8bit_core.sv]
// Counting pass: one pixel transfer per cycle unless input is held, no results.
// Table build after the last counting pixel, input held: a drain state, then
// for each bin read, accumulate, scale, 8 divide steps, table write.
// Remap pass: one pixel per cycle while the result output is not stalled, result valid in the cycle after its transfer.
// Input is held in the cycle after each write to a region size register.
// Reset (async, rst_n low): sizes 1x1, histogram and counters cleared, table undefined.
module histogram_equalizer_8bit_core
    import heq_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata,
    heq_in_if.sink               pixel_stream,
    heq_out_if.source            result_stream
);

    heq_cmd_t cmd;
    heq_sts_t sts;

    heq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    heq_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .pix_in    (pixel_stream),
        .pix_out   (result_stream)
    );

endmodule

[rtl/core/heq_ctrl.sv]
module heq_ctrl
    import heq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  heq_sts_t sts,
    output heq_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_COUNT,
        ST_DRAIN,
        ST_RD,
        ST_ACC,
        ST_MUL,
        ST_DIV,
        ST_WR,
        ST_REMAP
    } state_t;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W - 1);
    localparam logic [BIN_W-1:0]  BIN_LAST  = BIN_W'(BINS - 1);

    state_t            state_reg, state_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_COUNT:
            begin
                if (sts.count_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_RD;
            ST_RD:    state_next = ST_ACC;
            ST_ACC:   state_next = ST_MUL;
            ST_MUL:
            begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                bin_next = bin_reg + 1'b1;
                if (bin_reg == BIN_LAST)
                begin
                    state_next = ST_REMAP;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_REMAP:
            begin
                if (sts.remap_last)
                begin
                    state_next = ST_COUNT;
                end
            end
            default: state_next = ST_COUNT;
        endcase
        if (sts.cfg_wr)
        begin
            state_next = ST_COUNT;
            bin_next   = '0;
            step_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COUNT;
            bin_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bin_reg   <= bin_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cmd.count_en = (state_reg == ST_COUNT);
        cmd.remap_en = (state_reg == ST_REMAP);
        cmd.acc      = (state_reg == ST_ACC);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.div      = (state_reg == ST_DIV);
        cmd.wr_tbl   = (state_reg == ST_WR);
        cmd.bin      = bin_reg;
    end

    // bin position is back at zero whenever a region is being counted
    a_bin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT) |-> (bin_reg == '0))
        else $error("bin index not zero while counting");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_reg == STEP_LAST)
            |=> (state_reg == ST_WR || state_reg == ST_COUNT))
        else $error("divider ran past its last step");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        sts.remap_last |=> (state_reg == ST_COUNT))
        else $error("no restart after final remapped pixel");

endmodule

[rtl/core/heq_datapath.sv]
module heq_datapath
    import heq_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  heq_cmd_t             cmd,
    output heq_sts_t             sts,
    heq_in_if.sink               pix_in,
    heq_out_if.source            pix_out
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CNT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
    localparam int XW     = CNT_W + MAP_MUL_W;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (v == '0)
            clamp_side = SIDE_W'(1);
        else if (ve > CMP_W'(MAX_SIDE))
            clamp_side = SIDE_W'(MAX_SIDE);
        else
            clamp_side = SIDE_W'(ve);
    endfunction

    // configuration and region size
    logic [CFG_W-1:0]    width_reg, height_reg;
    logic [CNT_W-1:0]    n_reg;
    logic                cfg_pend_reg;
    logic                cfg_hit;
    logic [SIDE_W-1:0]   side_w, side_h;
    logic [2*SIDE_W-1:0] n_prod;

    assign cfg_hit = cfg_we && (cfg_idx == REG_ROI_WIDTH || cfg_idx == REG_ROI_HEIGHT);
    assign side_w  = clamp_side(width_reg);
    assign side_h  = clamp_side(height_reg);
    assign n_prod  = side_w * side_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_W'(1);
            height_reg   <= CFG_W'(1);
            n_reg        <= CNT_W'(1);
            cfg_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_idx == REG_ROI_WIDTH)
                width_reg <= cfg_wdata;
            if (cfg_we && cfg_idx == REG_ROI_HEIGHT)
                height_reg <= cfg_wdata;
            n_reg        <= n_prod[CNT_W-1:0];
            cfg_pend_reg <= cfg_hit;
        end
    end

    // input handshake and pass counter
    logic             out_vld_reg, last_reg;
    logic             in_rdy, in_xfer, cnt_acc, rmp_acc;
    logic [CNT_W-1:0] cnt_reg, cnt_inc;
    logic             at_end, restart;

    assign in_rdy  = !cfg_pend_reg
                     && (cmd.count_en || (cmd.remap_en && (!out_vld_reg || pix_out.ready)));
    assign in_xfer = pix_in.valid && in_rdy;
    assign cnt_acc = in_xfer && cmd.count_en;
    assign rmp_acc = in_xfer && cmd.remap_en;
    assign cnt_inc = cnt_reg + 1'b1;
    assign at_end  = (cnt_inc == n_reg);
    assign restart = cfg_hit || (rmp_acc && at_end);

    assign pix_in.ready   = in_rdy;
    assign sts.cfg_wr     = cfg_hit;
    assign sts.count_last = cnt_acc && at_end;
    assign sts.remap_last = rmp_acc && at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cfg_hit || ((cnt_acc || rmp_acc) && at_end))
            cnt_reg <= '0;
        else if (cnt_acc || rmp_acc)
            cnt_reg <= cnt_inc;
    end

    // histogram: read, then increment and write in the following cycle
    logic [CNT_W-1:0] hist_mem [BINS];
    logic [BINS-1:0]  hist_vld_reg;
    logic [BIN_W-1:0] hist_raddr;
    logic [CNT_W-1:0] hrd_reg;
    logic             hrd_vld_reg;
    logic             s1_vld_reg;
    logic [BIN_W-1:0] s1_addr_reg;
    logic             wr_vld_reg;
    logic [BIN_W-1:0] wr_addr_reg;
    logic [CNT_W-1:0] wr_data_reg;
    logic [CNT_W-1:0] hist_base, hist_inc;

    assign hist_raddr = cmd.count_en ? pix_in.pixel_in : cmd.bin;
    assign hist_base  = (wr_vld_reg && wr_addr_reg == s1_addr_reg) ? wr_data_reg
                      : (hrd_vld_reg ? hrd_reg : '0);
    assign hist_inc   = hist_base + 1'b1;

    always_ff @(posedge clk)
    begin
        hrd_reg <= hist_mem[hist_raddr];
        if (s1_vld_reg)
            hist_mem[s1_addr_reg] <= hist_inc;
        s1_addr_reg <= pix_in.pixel_in;
        wr_addr_reg <= s1_addr_reg;
        wr_data_reg <= hist_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            hrd_vld_reg  <= 1'b0;
            s1_vld_reg   <= 1'b0;
            wr_vld_reg   <= 1'b0;
        end
        else
        begin
            hrd_vld_reg <= hist_vld_reg[hist_raddr];
            s1_vld_reg  <= cnt_acc;
            wr_vld_reg  <= s1_vld_reg && !restart;
            if (restart)
                hist_vld_reg <= '0;
            else if (s1_vld_reg)
                hist_vld_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // table build: running sum, scaled numerator, restoring divide by 2N
    logic [CNT_W-1:0] sum_reg;
    logic [XW-1:0]    rem_reg, dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic             q_ge;

    assign q_ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (restart)
            sum_reg <= '0;
        else if (cmd.acc)
            sum_reg <= sum_reg + (hrd_vld_reg ? hrd_reg : '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            rem_reg <= XW'(sum_reg) * XW'(MAP_MUL) + XW'(n_reg);
            dsh_reg <= XW'(n_reg) << Q_W;
            q_reg   <= '0;
        end
        else if (cmd.div)
        begin
            if (q_ge)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[Q_W-2:0], q_ge};
        end
    end

    // remap table and output register
    logic [PIX_W-1:0] remap_mem [BINS];
    logic [PIX_W-1:0] rmp_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_tbl)
            remap_mem[cmd.bin] <= q_reg;
        if (rmp_acc)
        begin
            rmp_rd_reg <= remap_mem[pix_in.pixel_in];
            last_reg   <= at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (rmp_acc)
            out_vld_reg <= 1'b1;
        else if (pix_out.ready)
            out_vld_reg <= 1'b0;
    end

    assign pix_out.valid      = out_vld_reg;
    assign pix_out.pixel_out  = rmp_rd_reg;
    assign pix_out.last_pixel = last_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < n_reg)
        else $error("pass counter reached region size");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(rmp_acc))
        else $error("result without a remap transfer");

    // a histogram update must be done before the build reads the bins
    a_upd_done: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> !(cmd.acc || cmd.mul || cmd.remap_en))
        else $error("histogram update overlaps table build");

endmodule

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import heq_pkg::*;

    localparam int SETTLE_CYCLES  = 3200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 350;
    localparam int PARTIAL_PIXELS = 64;
    localparam int TAIL_CYCLES    = 20;
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 2'd3;

    localparam int STYLE_SPREAD = 0;
    localparam int STYLE_NARROW = 1;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             last;
    } remap_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    heq_in_if  pix_if ();
    heq_out_if res_if ();

    histogram_equalizer_8bit_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .pixel_stream  (pix_if),
        .result_stream (res_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // equalizer state mirror
    logic [20:0]      hist_count [BINS];
    logic [PIX_W-1:0] level_map [BINS];
    bit               remap_phase;
    int unsigned      pass_count;
    logic [CFG_W-1:0] roi_w;
    logic [CFG_W-1:0] roi_h;

    remap_result_t remap_q [$];

    bit          no_idle = 1'b0;
    int          stall = 0;
    int          idle_cycles = 0;
    int unsigned errors = 0;
    int unsigned pixels_sent = 0;
    int unsigned results_seen = 0;
    int unsigned regions_done = 0;
    int unsigned cfg_writes = 0;

    function automatic int unsigned clamp_side(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE_DEF)
            return MAX_SIDE_DEF;
        return 32'(v);
    endfunction

    function automatic int unsigned region_size();
        return clamp_side(roi_w) * clamp_side(roi_h);
    endfunction

    function automatic void clear_region();
        foreach (hist_count[i])
            hist_count[i] = '0;
        remap_phase = 1'b0;
        pass_count  = 0;
    endfunction

    // entry g = floor((cum[g]*510 + n) / (2n)), round half up of cdf*255
    function automatic void build_level_map(input int unsigned n);
        longint unsigned cum;
        longint unsigned v;
        longint unsigned den;
        cum = 0;
        den = 2 * longint'(n);
        for (int g = 0; g < BINS; g++)
        begin
            cum += hist_count[g];
            v = (cum * MAP_MUL + n) / den;
            if (v > 255)
                v = 255;
            level_map[g] = v[PIX_W-1:0];
        end
    endfunction

    function automatic void predict_pixel(input logic [PIX_W-1:0] px);
        int unsigned   n;
        remap_result_t r;
        n = region_size();
        if (!remap_phase)
        begin
            hist_count[px] = hist_count[px] + 1'b1;
            pass_count++;
            if (pass_count >= n)
            begin
                build_level_map(n);
                remap_phase = 1'b1;
                pass_count  = 0;
            end
        end
        else
        begin
            pass_count++;
            r.level = level_map[px];
            r.last  = (pass_count >= n);
            remap_q.push_back(r);
            if (r.last)
            begin
                clear_region();
                regions_done++;
            end
        end
    endfunction

    function automatic logic [PIX_W-1:0] draw_level(input int style, input logic [PIX_W-1:0] base);
        if (style == STYLE_SPREAD)
            return PIX_W'($urandom_range(0, 255));
        return base + PIX_W'($urandom_range(0, 3));
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= px;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        predict_pixel(px);
        pixels_sent++;
    endtask

    task automatic drain_results();
        pix_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (remap_q.size() != 0);
    endtask

    // the block may still be building its table after a counting pixel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ROI_WIDTH)
        begin
            roi_w = val;
            clear_region();
        end
        else if (idx == REG_ROI_HEIGHT)
        begin
            roi_h = val;
            clear_region();
        end
        cfg_writes++;
    endtask

    task automatic set_region(input int unsigned w, input int unsigned h);
        write_reg(REG_ROI_WIDTH, CFG_W'(w));
        write_reg(REG_ROI_HEIGHT, CFG_W'(h));
    endtask

    task automatic run_region(input int style, input int unsigned pause_at);
        int unsigned      n;
        logic [PIX_W-1:0] base;
        n    = region_size();
        base = PIX_W'($urandom_range(0, 255));
        for (int unsigned i = 0; i < 2 * n; i++)
        begin
            if (pause_at != 0 && i == pause_at)
                drain_results();
            send_pixel(draw_level(style, base));
        end
    endtask

    task automatic check_result(input logic [PIX_W-1:0] act_level, input logic act_last);
        remap_result_t exp_r;
        if (remap_q.size() == 0)
        begin
            $display("%0t: result with nothing expected: level %0d last %0b",
                     $time, act_level, act_last);
            errors++;
        end
        else
        begin
            exp_r = remap_q.pop_front();
            if (exp_r.level !== act_level)
            begin
                $display("%0t: pixel_out expected %0d actual %0d", $time, exp_r.level, act_level);
                errors++;
            end
            if (exp_r.last !== act_last)
            begin
                $display("%0t: last_pixel expected %0b actual %0b", $time, exp_r.last, act_last);
                errors++;
            end
        end
        results_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                check_result(res_if.pixel_out, res_if.last_pixel);
                stall = no_idle ? 0 : $urandom_range(0, 9);
            end
            else if (stall > 0)
                stall--;
            res_if.ready <= (stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // 1x1 region straight out of reset
    task automatic test_reset_size();
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
    endtask

    // darkest and brightest levels, back-to-back so the first remap pixel
    // follows the table build directly
    task automatic test_level_extremes();
        set_region(2, 2);
        no_idle = 1'b1;
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        no_idle = 1'b0;
    endtask

    task automatic test_abandon();
        set_region(2, 1);
        // mid counting
        send_pixel(8'h5a);
        write_reg(REG_ROI_WIDTH, CFG_W'(2));
        // mid remap
        send_pixel(8'h12);
        send_pixel(8'hc3);
        send_pixel(8'h12);
        write_reg(REG_ROI_HEIGHT, CFG_W'(1));
        // unused index leaves the region running
        send_pixel(8'h80);
        write_reg(SPARE_REG_IDX, CFG_W'(5));
        send_pixel(8'h7f);
        send_pixel(8'h7f);
        send_pixel(8'h80);
    endtask

    task automatic test_random();
        int unsigned stop_at;
        int unsigned n;
        int unsigned k;
        int          style;
        stop_at = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < stop_at)
        begin
            if ($urandom_range(0, 2) == 0)
                set_region($urandom_range(1, 6), $urandom_range(1, 4));
            n       = region_size();
            no_idle = ($urandom_range(0, 3) == 0);
            style   = $urandom_range(0, 1) ? STYLE_NARROW : STYLE_SPREAD;
            if ($urandom_range(0, 9) == 0)
            begin
                k = $urandom_range(1, 2 * n - 1);
                for (int unsigned i = 0; i < k; i++)
                    send_pixel(draw_level(STYLE_SPREAD, 8'd0));
                write_reg(REG_ROI_WIDTH, roi_w);
            end
            else if ($urandom_range(0, 4) == 0)
                run_region(style, $urandom_range(1, 2 * n - 1));
            else
                run_region(style, 0);
            no_idle = 1'b0;
        end
    endtask

    // zero sizes read as one, oversize width reads as the largest side
    task automatic test_clamped_sizes();
        set_region(0, 3);
        run_region(STYLE_SPREAD, 0);
        set_region(5, 0);
        run_region(STYLE_NARROW, 0);
        // oversize region only counts, then is abandoned
        set_region(2047, 0);
        no_idle = 1'b1;
        for (int i = 0; i < PARTIAL_PIXELS; i++)
            send_pixel(draw_level(STYLE_SPREAD, 8'd0));
        no_idle = 1'b0;
        write_reg(REG_ROI_WIDTH, CFG_W'(1));
        run_region(STYLE_SPREAD, 0);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_wdata       = '0;
        pix_if.valid    = 1'b0;
        pix_if.pixel_in = '0;
        res_if.ready    = 1'b1;
        roi_w           = CFG_W'(1);
        roi_h           = CFG_W'(1);
        clear_region();
        foreach (level_map[i])
            level_map[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size();
        test_level_extremes();
        test_abandon();
        test_random();
        test_clamped_sizes();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (remap_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, remap_q.size());
            errors += remap_q.size();
        end
        $display("Ran %0d pixel transfers, %0d results, %0d regions, %0d register writes.",
                 pixels_sent, results_seen, regions_done, cfg_writes);
        $display("Regions of 1 to 24 pixels, zero and oversize sizes, abandoned regions, full-rate passes.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
